// ----- rtl/core/calendar_date_arithmetic_top_assert.svh -----
// Assertion macros for the calendar date arithmetic block.
`ifndef CALENDAR_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_TOP_ASSERT_SVH

// Antecedent holds on an edge -> consequent holds on the same edge.
`define CDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cda assertion failed");

// Antecedent holds on an edge -> consequent holds on the next edge.
`define CDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cda assertion failed");

`endif

// ----- rtl/core/cda_pkg.sv -----
// Shared types, constants and calendar tables for the date arithmetic pipeline.
`default_nettype none

package cda_pkg;

  localparam int unsigned BaseYear   = 1900;
  localparam int unsigned LastYear   = 9999;
  localparam int unsigned BaseLeaps  = 460;   // leap years in 1..1899
  localparam int unsigned Div100Mul  = 5243;  // floor(x/100) = (x*Div100Mul) >> Div100Shift
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned Div7Mul    = 4682;  // floor(x/7) = (x*Div7Mul) >> Div7Shift
  localparam int unsigned Div7Shift  = 15;
  localparam int unsigned MinPerDay  = 1440;
  localparam int unsigned MinPerHour = 60;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonDec = 4'd12;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } in_t;

  typedef struct packed {
    logic [31:0] minutes_since_base;
    logic [2:0]  weekday;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic [4:0]  prev_day;
    logic [3:0]  prev_month;
    logic [13:0] prev_year;
    logic        date_valid;
  } out_t;

  // after the divide-by-100 multipliers
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [13:0] year_m1;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [7:0]  cent;      // year / 100
    logic [7:0]  cent_m1;   // (year - 1) / 100
  } s1_t;

  // after validity, leap year and year count
  typedef struct packed {
    logic        date_ok;
    logic        leap;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  mdays;
    logic [21:0] year_days;
    logic [6:0]  zk;
    logic [7:0]  zj;
  } s2_t;

  // after day count, neighbor dates and Zeller sum
  typedef struct packed {
    logic        date_ok;
    logic [21:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [10:0] zsum;
    logic [4:0]  nd;
    logic [3:0]  nm;
    logic [13:0] ny;
    logic [4:0]  pd;
    logic [3:0]  pm;
    logic [13:0] py;
  } s3_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // floor(13*(zm+1)/5), Jan and Feb counted as months 13 and 14
  function automatic logic [5:0] zeller_month(input logic [3:0] m);
    logic [5:0] v;
    case (m)
      4'd1:    v = 6'd36;
      4'd2:    v = 6'd39;
      4'd3:    v = 6'd10;
      4'd4:    v = 6'd13;
      4'd5:    v = 6'd15;
      4'd6:    v = 6'd18;
      4'd7:    v = 6'd20;
      4'd8:    v = 6'd23;
      4'd9:    v = 6'd26;
      4'd10:   v = 6'd28;
      4'd11:   v = 6'd31;
      4'd12:   v = 6'd33;
      default: v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cda_split.sv -----
// Stage 1: century quotients of the year and the year before.
`default_nettype none

module cda_split (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cda_pkg::in_t  data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cda_pkg::s1_t  data_o,
  input  logic          ready_i
);

  logic         valid_q;
  cda_pkg::s1_t data_q, data_d;
  logic [26:0]  prod_y, prod_ym1;
  logic [13:0]  ym1;

  always_comb begin
    ym1      = data_i.year - 14'd1;
    prod_y   = 27'(data_i.year) * 27'(cda_pkg::Div100Mul);
    prod_ym1 = 27'(ym1) * 27'(cda_pkg::Div100Mul);
    data_d.day     = data_i.day;
    data_d.month   = data_i.month;
    data_d.year    = data_i.year;
    data_d.year_m1 = ym1;
    data_d.hour    = data_i.hour;
    data_d.minute  = data_i.minute;
    data_d.cent    = prod_y[cda_pkg::Div100Shift +: 8];
    data_d.cent_m1 = prod_ym1[cda_pkg::Div100Shift +: 8];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/cda_count.sv -----
// Stage 2: leap year, validity, days of whole years and Zeller year terms.
`default_nettype none

module cda_count (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cda_pkg::s1_t  data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cda_pkg::s2_t  data_o,
  input  logic          ready_i
);

  logic         valid_q;
  cda_pkg::s2_t data_q, data_d;
  logic [6:0]   rem_y, rem_ym1;
  logic         leap;
  logic [4:0]   mdays;
  logic [21:0]  span;

  always_comb begin
    rem_y   = 7'(data_i.year - 14'(data_i.cent) * 14'd100);
    rem_ym1 = 7'(data_i.year_m1 - 14'(data_i.cent_m1) * 14'd100);
    leap    = ((rem_y != 7'd0) && (data_i.year[1:0] == 2'd0)) ||
              ((rem_y == 7'd0) && (data_i.cent[1:0] == 2'd0));
    mdays   = cda_pkg::month_len(data_i.month, leap);
    span    = 22'(data_i.year - 14'(cda_pkg::BaseYear));

    data_d.date_ok = (data_i.month >= cda_pkg::MonJan) && (data_i.month <= cda_pkg::MonDec) &&
                     (data_i.year >= 14'(cda_pkg::BaseYear)) &&
                     (data_i.year <= 14'(cda_pkg::LastYear)) &&
                     (data_i.day != 5'd0) && (data_i.day <= mdays);
    data_d.leap      = leap;
    data_d.day       = data_i.day;
    data_d.month     = data_i.month;
    data_d.year      = data_i.year;
    data_d.hour      = data_i.hour;
    data_d.minute    = data_i.minute;
    data_d.mdays     = mdays;
    data_d.year_days = span * 22'd365 + 22'(data_i.year_m1 >> 2) - 22'(data_i.cent_m1) +
                       22'(data_i.cent_m1 >> 2) - 22'(cda_pkg::BaseLeaps);
    if (data_i.month <= cda_pkg::MonFeb) begin
      data_d.zk = rem_ym1;
      data_d.zj = data_i.cent_m1;
    end else begin
      data_d.zk = rem_y;
      data_d.zj = data_i.cent;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/cda_step.sv -----
// Stage 3: day count, following and preceding dates, Zeller sum.
`default_nettype none

module cda_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cda_pkg::s2_t  data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cda_pkg::s3_t  data_o,
  input  logic          ready_i
);

  logic         valid_q;
  cda_pkg::s3_t data_q, data_d;
  logic         late_leap;

  always_comb begin
    late_leap      = data_i.leap && (data_i.month > cda_pkg::MonFeb);
    data_d.date_ok = data_i.date_ok;
    data_d.hour    = data_i.hour;
    data_d.minute  = data_i.minute;
    data_d.days    = data_i.year_days + 22'(cda_pkg::days_before(data_i.month)) +
                     22'(late_leap) + 22'(data_i.day) - 22'd1;
    data_d.zsum    = 11'(data_i.day) + 11'(cda_pkg::zeller_month(data_i.month)) +
                     11'(data_i.zk) + 11'(data_i.zk >> 2) + 11'(data_i.zj >> 2) +
                     11'(data_i.zj) * 11'd5;

    if (data_i.day >= data_i.mdays) begin
      data_d.nd = 5'd1;
      if (data_i.month == cda_pkg::MonDec) begin
        data_d.nm = cda_pkg::MonJan;
        data_d.ny = data_i.year + 14'd1;
      end else begin
        data_d.nm = data_i.month + 4'd1;
        data_d.ny = data_i.year;
      end
    end else begin
      data_d.nd = data_i.day + 5'd1;
      data_d.nm = data_i.month;
      data_d.ny = data_i.year;
    end

    if (data_i.day == 5'd1) begin
      if (data_i.month == cda_pkg::MonJan) begin
        data_d.pm = cda_pkg::MonDec;
        data_d.py = data_i.year - 14'd1;
      end else begin
        data_d.pm = data_i.month - 4'd1;
        data_d.py = data_i.year;
      end
      data_d.pd = cda_pkg::month_len(data_d.pm, data_i.leap);
    end else begin
      data_d.pm = data_i.month;
      data_d.py = data_i.year;
      data_d.pd = data_i.day - 5'd1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/cda_finish.sv -----
// Stage 4: minute count, weekday reduction and output register.
`default_nettype none

module cda_finish (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  cda_pkg::s3_t  data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cda_pkg::out_t data_o,
  input  logic          ready_i
);

  logic          valid_q;
  cda_pkg::out_t data_q, data_d;
  logic [23:0]   prod7;
  logic [8:0]    quot7;
  logic [2:0]    zel;

  always_comb begin
    prod7 = 24'(data_i.zsum) * 24'(cda_pkg::Div7Mul);
    quot7 = prod7[cda_pkg::Div7Shift +: 9];
    zel   = 3'(data_i.zsum - 11'(quot7) * 11'd7);
    data_d = '0;
    if (data_i.date_ok) begin
      data_d.minutes_since_base = 32'(data_i.days) * 32'(cda_pkg::MinPerDay) +
                                  32'(data_i.hour) * 32'(cda_pkg::MinPerHour) +
                                  32'(data_i.minute);
      // Zeller counts from Saturday
      data_d.weekday    = (zel == 3'd0) ? 3'd6 : zel - 3'd1;
      data_d.next_day   = data_i.nd;
      data_d.next_month = data_i.nm;
      data_d.next_year  = data_i.ny;
      data_d.prev_day   = data_i.pd;
      data_d.prev_month = data_i.pm;
      data_d.prev_year  = data_i.py;
      data_d.date_valid = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/calendar_date_arithmetic_top.sv -----
// Top level of the Gregorian date arithmetic pipeline.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i  (cda_pkg::in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o (cda_pkg::out_t)
//
// Four register stages: /100 multipliers, year count, day count, minute multiply.
// Items pass split, count, step, finish; one transfer per cycle unless stalled.
// Reset clears only the stage valid bits; no clearing pass.
// A stall holds each full stage; empty stages keep filling, so no item is lost.
`default_nettype none

`include "calendar_date_arithmetic_top_assert.svh"

module calendar_date_arithmetic_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cda_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cda_pkg::out_t out_data_o
);

  logic         v1, v2, v3;
  logic         r1, r2, r3, r4;
  cda_pkg::s1_t d1;
  cda_pkg::s2_t d2;
  cda_pkg::s3_t d3;

  cda_split u_split (
    .clk_i, .rst_ni,
    .valid_i (in_valid_i), .data_i (in_data_i), .ready_o (r1),
    .valid_o (v1), .data_o (d1), .ready_i (r2)
  );

  cda_count u_count (
    .clk_i, .rst_ni,
    .valid_i (v1), .data_i (d1), .ready_o (r2),
    .valid_o (v2), .data_o (d2), .ready_i (r3)
  );

  cda_step u_step (
    .clk_i, .rst_ni,
    .valid_i (v2), .data_i (d2), .ready_o (r3),
    .valid_o (v3), .data_o (d3), .ready_i (r4)
  );

  cda_finish u_finish (
    .clk_i, .rst_ni,
    .valid_i (v3), .data_i (d3), .ready_o (r4),
    .valid_o (out_valid_o), .data_o (out_data_o), .ready_i (!out_stall_i)
  );

  assign in_stall_o = !r1;

  `CDA_ASSERT_SAME(a_invalid_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.date_valid, out_data_o == '0)
  `CDA_ASSERT_SAME(a_valid_fields, clk_i, rst_ni,
    out_valid_o && out_data_o.date_valid,
    out_data_o.weekday <= 3'd6 && out_data_o.next_day != 5'd0 &&
    out_data_o.prev_day != 5'd0 && out_data_o.next_month != 4'd0 &&
    out_data_o.prev_month != 4'd0)
  `CDA_ASSERT_NEXT(a_free_flow, clk_i, rst_ni,
    !out_stall_i && in_valid_i && !in_stall_o, v1)

endmodule

`default_nettype wire

// ----- tb/tb_calendar_date_arithmetic_top.sv -----
// Self-checking testbench for the calendar date arithmetic pipeline, random stalls on both sides.
`default_nettype none

module tb_calendar_date_arithmetic_top;

  localparam int unsigned RandomDates = 1400;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TailCycles  = 12;
  localparam int unsigned ReportMax   = 10;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  cda_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  cda_pkg::out_t out_data_o;

  calendar_date_arithmetic_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  int unsigned month_span [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_ahead [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  cda_pkg::in_t  pending_dates [$];
  cda_pkg::out_t expected_results [$];

  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned total_dates = 0;
  int unsigned sent_valid = 0;
  int unsigned sent_invalid = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          steady_run = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit is_leap(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == 2 && is_leap(y)) return 29;
    if (m > 12) return 0;
    return month_span[m];
  endfunction

  function automatic int unsigned leaps_through(int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic cda_pkg::out_t predict_date(cda_pkg::in_t t);
    cda_pkg::out_t r;
    int unsigned dd, mo, yr, hh, mi, days, zm, zy, zk, zj, zh;
    int unsigned nd, nm, ny, pd, pm, py;
    r  = '0;
    dd = t.day;
    mo = t.month;
    yr = t.year;
    hh = t.hour;
    mi = t.minute;
    if (mo < 1 || mo > 12 || yr < 1900 || yr > 9999 || dd < 1 || dd > days_in_month(mo, yr))
      return r;
    days = 365 * (yr - 1900) + leaps_through(yr - 1) - leaps_through(1899) + days_ahead[mo]
         + ((mo > 2 && is_leap(yr)) ? 1 : 0) + dd - 1;
    r.minutes_since_base = days * 1440 + hh * 60 + mi;
    // Zeller, January and February as months 13 and 14 of the prior year
    zm = mo;
    zy = yr;
    if (zm < 3) begin
      zm += 12;
      zy -= 1;
    end
    zk = zy % 100;
    zj = zy / 100;
    zh = (dd + (13 * (zm + 1)) / 5 + zk + zk / 4 + zj / 4 + 5 * zj) % 7;
    r.weekday = 3'((zh + 6) % 7);
    nd = dd + 1;
    nm = mo;
    ny = yr;
    if (nd > days_in_month(mo, yr)) begin
      nd = 1;
      nm += 1;
      if (nm > 12) begin
        nm = 1;
        ny += 1;
      end
    end
    pd = dd - 1;
    pm = mo;
    py = yr;
    if (pd < 1) begin
      pm -= 1;
      if (pm < 1) begin
        pm = 12;
        py -= 1;
      end
      pd = days_in_month(pm, py);
    end
    r.next_day   = 5'(nd);
    r.next_month = 4'(nm);
    r.next_year  = 14'(ny);
    r.prev_day   = 5'(pd);
    r.prev_month = 4'(pm);
    r.prev_year  = 14'(py);
    r.date_valid = 1'b1;
    return r;
  endfunction

  function automatic cda_pkg::in_t mk_date(int unsigned d, int unsigned m, int unsigned y,
                                           int unsigned h, int unsigned mi);
    cda_pkg::in_t t;
    t.day    = 5'(d);
    t.month  = 4'(m);
    t.year   = 14'(y);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    return t;
  endfunction

  function automatic cda_pkg::in_t random_date();
    cda_pkg::in_t t;
    logic [63:0]  raw;
    int unsigned  pick, ysel, y, m, len, dsel;
    pick = $urandom_range(99);
    ysel = $urandom_range(99);
    if (ysel < 20)
      y = ($urandom_range(1)) ? 1900 + $urandom_range(3) : 9996 + $urandom_range(3);
    else if (ysel < 35)
      y = 100 * $urandom_range(99, 19);
    else if (ysel < 55)
      y = 4 * $urandom_range(2499, 475);
    else
      y = $urandom_range(9999, 1900);
    m    = $urandom_range(12, 1);
    len  = days_in_month(m, y);
    dsel = $urandom_range(99);
    if (dsel < 25)      t.day = 5'(len);
    else if (dsel < 35) t.day = 5'd1;
    else                t.day = 5'($urandom_range(len, 1));
    t.month  = 4'(m);
    t.year   = 14'(y);
    t.hour   = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    t.minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
    if (pick >= 85) begin
      case ($urandom_range(3))
        0: begin
          raw = {$urandom(), $urandom()};
          t   = raw[$bits(cda_pkg::in_t)-1:0];
        end
        1: t.day = (len == 31) ? 5'd0 : 5'($urandom_range(31, len + 1));
        2: t.year = ($urandom_range(1)) ? 14'($urandom_range(1899)) :
                                          14'($urandom_range(16383, 10000));
        default: t.month = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
      endcase
    end
    return t;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (steady_run || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic string show_result(cda_pkg::out_t r);
    return $sformatf("min=%0d wd=%0d next=%0d-%0d-%0d prev=%0d-%0d-%0d ok=%0b",
                     r.minutes_since_base, r.weekday, r.next_year, r.next_month, r.next_day,
                     r.prev_year, r.prev_month, r.prev_day, r.date_valid);
  endfunction

  // input side: one transfer per slot, random gaps between
  always @(posedge clk_i) begin
    cda_pkg::out_t sent;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sent = predict_date(in_data_i);
        expected_results.push_back(sent);
        if (sent.date_valid) sent_valid++;
        else                 sent_invalid++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_dates.size() > 0) begin
          in_data_i  <= pending_dates.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(63) == 0) steady_run = ~steady_run;
          send_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: check each transfer, random stalls
  always @(posedge clk_i) begin
    cda_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= ReportMax)
            $display("unexpected result: %s", show_result(out_data_o));
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_data_o !== want) begin
            errors++;
            if (errors <= ReportMax)
              $display("result %0d mismatch\n  exp %s\n  got %s", checked,
                       show_result(want), show_result(out_data_o));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("tb_calendar_date_arithmetic_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    // base date, top of range, leap rules, rollovers, invalid fields
    pending_dates.push_back(mk_date(1, 1, 1900, 0, 0));
    pending_dates.push_back(mk_date(31, 12, 9999, 23, 59));
    pending_dates.push_back(mk_date(29, 2, 2000, 12, 30));
    pending_dates.push_back(mk_date(28, 2, 1900, 1, 1));
    pending_dates.push_back(mk_date(29, 2, 1900, 1, 1));
    pending_dates.push_back(mk_date(29, 2, 2024, 6, 0));
    pending_dates.push_back(mk_date(29, 2, 2023, 6, 0));
    pending_dates.push_back(mk_date(29, 2, 2100, 6, 0));
    pending_dates.push_back(mk_date(31, 12, 2023, 23, 59));
    pending_dates.push_back(mk_date(1, 1, 2024, 0, 0));
    pending_dates.push_back(mk_date(1, 3, 2024, 8, 15));
    pending_dates.push_back(mk_date(1, 3, 2023, 8, 15));
    pending_dates.push_back(mk_date(30, 4, 2024, 10, 10));
    pending_dates.push_back(mk_date(31, 4, 2024, 10, 10));
    pending_dates.push_back(mk_date(31, 1, 5000, 3, 3));
    pending_dates.push_back(mk_date(15, 0, 2024, 0, 0));
    pending_dates.push_back(mk_date(15, 13, 2024, 0, 0));
    pending_dates.push_back(mk_date(15, 15, 2024, 0, 0));
    pending_dates.push_back(mk_date(0, 6, 2024, 0, 0));
    pending_dates.push_back(mk_date(31, 12, 1899, 0, 0));
    pending_dates.push_back(mk_date(1, 1, 10000, 0, 0));
    pending_dates.push_back(mk_date(31, 12, 9999, 31, 63));
    pending_dates.push_back(mk_date(31, 15, 16383, 31, 63));
    pending_dates.push_back(mk_date(0, 0, 0, 0, 0));
    pending_dates.push_back(mk_date(31, 8, 8192, 0, 0));
    repeat (RandomDates) pending_dates.push_back(random_date());
    total_dates = pending_dates.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the watchdog ends the run if a result never shows up
    while (checked < total_dates)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    errors += expected_results.size();

    $display("sent %0d valid and %0d invalid dates, checked %0d results",
             sent_valid, sent_invalid, checked);
    $display("covered leap rules, month and year rollover, range edges, out-of-range fields");
    if (errors == 0) begin
      $display("tb_calendar_date_arithmetic_top: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_calendar_date_arithmetic_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
